// File: rtl/core/four_neighbour_edge_and_blur_assert.svh
// ----------------------------------------------------------------------------
// four_neighbour_edge_and_blur_assert.svh
// Assertion macros for the edge/blur stencil modules (used by fnb_out).
// ----------------------------------------------------------------------------
`ifndef FOUR_NEIGHBOUR_EDGE_AND_BLUR_ASSERT_SVH
`define FOUR_NEIGHBOUR_EDGE_AND_BLUR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FNB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FNB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fnb_pkg.sv
// ----------------------------------------------------------------------------
// fnb_pkg
// Shared constants, types and helpers of the edge/blur stencil.
// ----------------------------------------------------------------------------
package fnb_pkg;

    localparam int MAX_SIZE = 1024;
    localparam int MIN_SIZE = 3;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int SIZE_W   = 11;
    localparam int PIX_W    = 8;
    localparam int EDGE_W   = 10;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [PIX_W-1:0]  t_pix;

    // position info of the beat being accepted
    typedef struct packed {
        t_addr x;
        t_addr xp1;
        logic  has_res;   // row above exists: one result
        logic  two_res;   // last row: also its own zero result
        logic  interior;
        logic  col_last;
    } t_pos;

    // clamp the programmed size and return the last column/row index
    function automatic t_addr f_last_idx(input t_size v);
        int s;
        s = int'(v);
        if (s < MIN_SIZE) s = MIN_SIZE;
        if (s > MAX_SIZE) s = MAX_SIZE;
        return t_addr'(s - 1);
    endfunction

endpackage

// File: rtl/core/fnb_scan.sv
// ----------------------------------------------------------------------------
// fnb_scan
// Raster position counters and size register; classifies each input beat.
// ----------------------------------------------------------------------------
module fnb_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  fnb_pkg::t_size i_cfg_data,
    input  logic          i_accept,
    output fnb_pkg::t_pos o_pos
);
    import fnb_pkg::*;

    t_addr r_x, n_x;
    t_addr r_r, n_r;
    t_addr r_last_idx;

    always_comb begin
        n_x = r_x;
        n_r = r_r;
        if (i_accept) begin
            if (r_x == r_last_idx) begin
                n_x = '0;
                n_r = (r_r == r_last_idx) ? '0 : t_addr'(r_r + 1'b1);
            end else begin
                n_x = t_addr'(r_x + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_r        <= '0;
            r_last_idx <= t_addr'(MAX_SIZE - 1);
        end else if (i_cfg_we) begin
            // a size write restarts the frame
            r_x        <= '0;
            r_r        <= '0;
            r_last_idx <= f_last_idx(i_cfg_data);
        end else begin
            r_x <= n_x;
            r_r <= n_r;
        end
    end

    always_comb begin
        o_pos.x        = r_x;
        o_pos.xp1      = t_addr'(r_x + 1'b1);
        o_pos.has_res  = (r_r != '0);
        o_pos.two_res  = (r_r == r_last_idx);
        o_pos.interior = (r_x != '0) && (r_x != r_last_idx) && (r_r > t_addr'(1));
        o_pos.col_last = (r_x == r_last_idx);
    end

endmodule

// File: rtl/core/fnb_line_buf.sv
// ----------------------------------------------------------------------------
// fnb_line_buf
// Two line memories: center row (1 write, 2 reads) and row above (1 w, 1 r).
// ----------------------------------------------------------------------------
module fnb_line_buf (
    input  logic           i_clk,
    input  logic           i_accept,
    input  fnb_pkg::t_addr i_x,
    input  fnb_pkg::t_addr i_xp1,
    input  fnb_pkg::t_pix  i_pixel,
    input  logic           i_wa_en,
    input  fnb_pkg::t_addr i_wa_addr,
    output fnb_pkg::t_pix  o_left,
    output fnb_pkg::t_pix  o_right,
    output fnb_pkg::t_pix  o_up
);
    import fnb_pkg::*;

    t_pix r_center [MAX_SIZE];
    t_pix r_above  [MAX_SIZE];

    t_pix r_rd_c0;   // old center[x]: goes to row above, and is next beat's left
    t_pix r_rd_c1;   // old center[x+1]: right neighbour
    t_pix r_rd_a;    // old above[x]: up neighbour
    t_pix r_left;

    // reads see the contents before this edge's write
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_c0     <= r_center[i_x];
            r_rd_c1     <= r_center[i_xp1];
            r_rd_a      <= r_above[i_x];
            r_left      <= r_rd_c0;
            r_center[i_x] <= i_pixel;
        end
    end

    // delayed move of old center[x] into the row above; repeats while held
    always_ff @(posedge i_clk) begin
        if (i_wa_en) begin
            r_above[i_wa_addr] <= r_rd_c0;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_rd_c1;
    assign o_up    = r_rd_a;

endmodule

// File: rtl/core/fnb_out.sv
// ----------------------------------------------------------------------------
// fnb_out
// Compute stage and output register; sequences the one or two result beats of a pixel (none on the first row).
// ----------------------------------------------------------------------------
module fnb_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_accept,
    input  fnb_pkg::t_pos       i_pos,
    input  fnb_pkg::t_pix       i_pixel,
    input  fnb_pkg::t_pix       i_left,
    input  fnb_pkg::t_pix       i_right,
    input  fnb_pkg::t_pix       i_up,
    output logic                o_wa_en,
    output fnb_pkg::t_addr      o_wa_addr,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [fnb_pkg::EDGE_W-1:0] o_edge_value,
    output fnb_pkg::t_pix       o_smooth_value,
    output logic                o_last_result
);
    import fnb_pkg::*;

    logic  r_s1_valid;
    t_pos  r_s1_pos;
    logic  r_s1_phase;
    t_pix  r_s1_pix;

    logic  r_out_valid;
    logic signed [EDGE_W-1:0] r_edge;
    t_pix  r_smooth;
    logic  r_last;

    logic  out_free, emit, s1_done, accept;
    logic [PIX_W:0]   sum_lu, sum_rd;
    logic [PIX_W+1:0] sum4;
    logic signed [EDGE_W-1:0] n_edge;
    t_pix  n_smooth;
    logic  n_last;

    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        emit       = r_s1_valid && r_s1_pos.has_res && out_free;
        s1_done    = r_s1_valid && (!r_s1_pos.has_res
                     || (out_free && (!r_s1_pos.two_res || r_s1_phase)));
        o_in_stall = r_s1_valid && !s1_done;
        accept     = i_in_valid && !o_in_stall;
    end

    always_comb begin
        sum_lu = {1'b0, i_left}  + {1'b0, i_up};
        sum_rd = {1'b0, i_right} + {1'b0, r_s1_pix};
        sum4   = {1'b0, sum_lu} + {1'b0, sum_rd};
        n_edge   = '0;
        n_smooth = '0;
        n_last   = 1'b0;
        if (r_s1_phase) begin
            n_last = r_s1_pos.col_last;
        end else if (r_s1_pos.interior) begin
            n_edge   = $signed({1'b0, sum_lu}) - $signed({1'b0, sum_rd});
            n_smooth = sum4[PIX_W+1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_s1_phase <= 1'b0;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (emit) begin
            r_s1_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos <= i_pos;
            r_s1_pix <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_edge   <= n_edge;
            r_smooth <= n_smooth;
            r_last   <= n_last;
        end
    end

    assign o_accept       = accept;
    assign o_wa_en        = r_s1_valid;
    assign o_wa_addr      = r_s1_pos.x;
    assign o_out_valid    = r_out_valid;
    assign o_edge_value   = r_edge;
    assign o_smooth_value = r_smooth;
    assign o_last_result  = r_last;

`include "four_neighbour_edge_and_blur_assert.svh"

    `FNB_ASSERT_IMP(a_phase_two, r_s1_phase, r_s1_valid && r_s1_pos.two_res, "bad second beat")
    `FNB_ASSERT_IMP(a_last_zero, r_out_valid && r_last, r_edge == '0 && r_smooth == '0, "last nonzero")
    `FNB_ASSERT_NXT(a_first_of_two, emit && r_s1_pos.two_res && !r_s1_phase, r_s1_valid && r_s1_phase, "lost second beat")
    `FNB_ASSERT_IMP(a_no_accept_busy, r_s1_valid && !s1_done, !accept, "accept while busy")

endmodule

// File: rtl/core/four_neighbour_edge_and_blur.sv
// ----------------------------------------------------------------------------
// four_neighbour_edge_and_blur
// Four-neighbour edge and blur stencil over a square 8-bit raster image.
//
//   channel  dir  handshake               payload
//   cfg      in   i_cfg_we                i_cfg_data (image_size)
//   pixel    in   i_in_valid/o_in_stall   i_pixel
//   result   out  o_out_valid/i_out_stall o_edge_value, o_smooth_value,
//                                         o_last_result
//
// One pixel beat per cycle while o_in_stall is low; results leave one row
// behind, via the compute-stage and output registers. Last-row pixels give
// two result beats each and are held until both enter the output register.
// The line memories need no clearing pass: reset only sets the counters,
// size register and flags. A size write restarts the frame.
// ----------------------------------------------------------------------------
module four_neighbour_edge_and_blur (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  fnb_pkg::t_size      i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fnb_pkg::t_pix       i_pixel,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [fnb_pkg::EDGE_W-1:0] o_edge_value,
    output fnb_pkg::t_pix       o_smooth_value,
    output logic                o_last_result
);
    import fnb_pkg::*;

    logic  accept;
    t_pos  pos;
    t_pix  left, right, up;
    logic  wa_en;
    t_addr wa_addr;

    fnb_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .o_pos      (pos)
    );

    fnb_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_accept  (accept),
        .i_x       (pos.x),
        .i_xp1     (pos.xp1),
        .i_pixel   (i_pixel),
        .i_wa_en   (wa_en),
        .i_wa_addr (wa_addr),
        .o_left    (left),
        .o_right   (right),
        .o_up      (up)
    );

    fnb_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .o_accept       (accept),
        .i_pos          (pos),
        .i_pixel        (i_pixel),
        .i_left         (left),
        .i_right        (right),
        .i_up           (up),
        .o_wa_en        (wa_en),
        .o_wa_addr      (wa_addr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_edge_value   (o_edge_value),
        .o_smooth_value (o_smooth_value),
        .o_last_result  (o_last_result)
    );

endmodule

// File: tb/edge_blur_checker.sv
// ----------------------------------------------------------------------------
// edge_blur_checker
// Watches the config, pixel and result channels of the edge/blur stencil,
// predicts every result beat from the accepted pixels and compares each
// accepted result beat field by field, oldest first.
// ----------------------------------------------------------------------------
module edge_blur_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  fnb_pkg::t_size                    i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  fnb_pkg::t_pix                     i_pixel,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [fnb_pkg::EDGE_W-1:0] i_edge_value,
    input  fnb_pkg::t_pix                     i_smooth_value,
    input  logic                              i_last_result,
    output int                                o_fail_count,
    output int                                o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import fnb_pkg::*;

    typedef struct packed {
        logic signed [EDGE_W-1:0] edge_value;
        t_pix                     smooth_value;
        logic                     last_result;
    } t_stencil_res;

    t_stencil_res pending_results[$];
    t_pix         above_row [MAX_SIZE];
    t_pix         center_row[MAX_SIZE];
    t_size        size_reg;
    int           col;
    int           row;
    int           fails;
    int           result_beats;

    initial begin
        o_fail_count  = 0;
        o_results_due = 0;
        fails         = 0;
        result_beats  = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH beat %0d: %s", $realtime, result_beats, msg);
        fails++;
    endtask

    // one pixel beat: expected results for the row above, plus the own zero
    // result when on the last row
    task automatic predict_stencil(input t_pix p);
        int           n;
        int           left;
        int           right;
        int           up;
        t_stencil_res res;
        n = int'(size_reg);
        if (n < MIN_SIZE) n = MIN_SIZE;
        if (n > MAX_SIZE) n = MAX_SIZE;
        if (row >= 1) begin
            res = '0;
            if (col >= 1 && col <= n - 2 && row >= 2) begin
                left  = int'(above_row[col - 1]);  // row r-1, already shifted
                right = int'(center_row[col + 1]); // row r-1
                up    = int'(above_row[col]);      // row r-2
                res.edge_value   = EDGE_W'((left + up) - (right + int'(p)));
                res.smooth_value = PIX_W'((left + right + up + int'(p)) >> 2);
            end
            pending_results.push_back(res);
            if (row == n - 1) begin
                res = '0;
                res.last_result = (col == n - 1);
                pending_results.push_back(res);
            end
        end
        above_row[col]  = center_row[col];
        center_row[col] = p;
        col++;
        if (col >= n) begin
            col = 0;
            row++;
            if (row >= n) row = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_stencil_res want;
        if (!i_rst_n) begin
            pending_results.delete();
            size_reg = t_size'(MAX_SIZE);
            col      = 0;
            row      = 0;
        end else begin
            if (i_cfg_we) begin
                size_reg = i_cfg_data;
                col      = 0;
                row      = 0;
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing pending (edge %0d smooth %0d last %0d)",
                        i_edge_value, i_smooth_value, i_last_result));
                end else begin
                    want = pending_results.pop_front();
                    if (i_edge_value !== want.edge_value)
                        report_mismatch($sformatf("edge_value got %0d, expected %0d",
                            i_edge_value, $signed(want.edge_value)));
                    if (i_smooth_value !== want.smooth_value)
                        report_mismatch($sformatf("smooth_value got %0d, expected %0d",
                            i_smooth_value, want.smooth_value));
                    if (i_last_result !== want.last_result)
                        report_mismatch($sformatf("last_result got %0b, expected %0b",
                            i_last_result, want.last_result));
                end
                result_beats++;
            end
            if (i_in_valid && !i_in_stall) predict_stencil(i_pixel);
        end
        o_fail_count  <= fails;
        o_results_due <= pending_results.size();
    end

endmodule

// File: tb/tb_four_neighbour_edge_and_blur.sv
// ----------------------------------------------------------------------------
// tb_four_neighbour_edge_and_blur
// Stimulus and verdict for the edge/blur stencil: directed frames with the
// edge and blur extremes, clamped sizes and a mid-frame restart, then random
// sizes and pixel streams under varying sender/receiver idling.
// ----------------------------------------------------------------------------
module tb_four_neighbour_edge_and_blur;
    timeunit 1ns;
    timeprecision 1ps;

    import fnb_pkg::*;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    t_size                     i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    t_pix                      i_pixel     = '0;
    logic                      i_out_stall = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic signed [EDGE_W-1:0]  o_edge_value;
    t_pix                      o_smooth_value;
    logic                      o_last_result;
    int                        fail_count;
    int                        results_due;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    // (1,1) gives edge +510, then edge -510
    t_pix frame_pos[9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    t_pix frame_neg[9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255,
                           8'd255, 8'd255, 8'd255};

    four_neighbour_edge_and_blur dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_edge_value   (o_edge_value),
        .o_smooth_value (o_smooth_value),
        .o_last_result  (o_last_result)
    );

    edge_blur_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_pixel        (i_pixel),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_edge_value   (o_edge_value),
        .i_smooth_value (o_smooth_value),
        .i_last_result  (o_last_result),
        .o_fail_count   (fail_count),
        .o_results_due  (results_due)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct <= receiver_pct;
    endtask

    function automatic t_pix rand_pixel();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return t_pix'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input t_pix p);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop sending, wait for every pending result, then let the pipe settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_image_size(input t_size v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int    random_items;
        int    phase_idx;
        int    pick;
        int    eff;
        int    cnt;
        int    pause_at;
        bit    paused_once;
        t_size size_val;

        random_items = 0;
        phase_idx    = 0;
        paused_once  = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, clamp below range, restart mid-frame, frame wrap
        set_idling(28, 73);
        write_image_size(t_size'(MIN_SIZE));
        foreach (frame_pos[k]) send_pixel(frame_pos[k]);
        drain_results();
        write_image_size(t_size'(0));
        repeat (5) send_pixel(rand_pixel());
        drain_results();
        write_image_size(t_size'(1));
        foreach (frame_neg[k]) send_pixel(frame_neg[k]);
        repeat (9) send_pixel(8'd255);
        drain_results();

        while (random_items < 450) begin
            if (random_items < 150) set_idling(28, 73);
            else if (random_items < 300) set_idling(73, 28);
            else set_idling(0, 0);

            pick = $urandom_range(0, 9);
            if (pick == 0) size_val = t_size'($urandom_range(0, 2));
            else if (pick == 1) size_val = t_size'($urandom_range(MAX_SIZE, 2047));
            else if (pick <= 3) size_val = t_size'($urandom_range(13, 40));
            else size_val = t_size'($urandom_range(MIN_SIZE, 12));

            eff = int'(size_val);
            if (eff < MIN_SIZE) eff = MIN_SIZE;
            if (eff > MAX_SIZE) eff = MAX_SIZE;
            if (eff >= MAX_SIZE) cnt = $urandom_range(1, 40);
            else if (eff <= 12) cnt = $urandom_range(1, 2 * eff * eff + eff);
            else cnt = $urandom_range(eff, 4 * eff);

            pause_at = -1;
            if (!paused_once && cnt > 2) begin
                pause_at    = $urandom_range(1, cnt - 1);
                paused_once = 1'b1;
            end

            write_image_size(size_val);
            for (int k = 0; k < cnt; k++) begin
                if (k == pause_at) drain_results();
                send_pixel(rand_pixel());
            end
            drain_results();
            random_items += cnt;
            phase_idx++;
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fnb_pkg.sv
rtl/core/fnb_scan.sv
rtl/core/fnb_line_buf.sv
rtl/core/fnb_out.sv
rtl/core/four_neighbour_edge_and_blur.sv
tb/edge_blur_checker.sv
tb/tb_four_neighbour_edge_and_blur.sv
